FILE: sv/mssp_pkg.sv
`timescale 1ns / 1ps

package mssp_pkg;

   localparam int CHANNELS_DEF     = 8;
   localparam int PERIOD_TICKS_DEF = 256;

   localparam int WIDTH_W      = 16;
   localparam int LINE_W       = 8;
   localparam int LINE_IDX_W   = 3;
   localparam int CHAN_FIELD_W = 3;
   localparam int CHAN_MAX_W   = 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [WIDTH_W-1:0] COUNT_MAX       = 16'hFFFF;
   localparam logic [WIDTH_W-1:0] FRAME_MIN_RESET = 16'd3333;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MIN     = 1'd1;

   typedef struct packed {
      logic                    operation;
      logic [CHAN_FIELD_W-1:0] channel;
      logic [WIDTH_W-1:0]      width;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0]       pulse_lines;
      logic [CHAN_FIELD_W-1:0] current_channel;
      logic                    frame_start;
   } rsp_type;

   // Write into the pending width store.
   typedef struct packed {
      logic                  en;
      logic [CHAN_MAX_W-1:0] chan;
      logic [WIDTH_W-1:0]    data;
   } wr_type;

endpackage

FILE: sv/mssp_pend_store.sv
`timescale 1ns / 1ps

module mssp_pend_store #(
   parameter int CHANNELS = mssp_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mssp_pkg::wr_type                    wr,
   input  logic [$clog2(CHANNELS)-1:0]         rd_addr,
   output logic [mssp_pkg::WIDTH_W-1:0]        rd_data
);
   import mssp_pkg::*;

   localparam int CHW = $clog2(CHANNELS);

   logic [WIDTH_W-1:0]  mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [WIDTH_W-1:0]  mem_rd_ff;
   logic                rd_valid_ff;
   logic                hit_ff;
   logic [WIDTH_W-1:0]  hit_data_ff;
   logic [CHW-1:0]      wr_idx;

   assign wr_idx = wr.chan[CHW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.data;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
         hit_ff      <= wr.en && (wr_idx == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      hit_data_ff <= wr.data;
   end

   // A write to the entry being read in the same cycle is forwarded.
   assign rd_data = hit_ff ? hit_data_ff : (rd_valid_ff ? mem_rd_ff : '0);

endmodule

FILE: sv/multiplexed_servo_pulse_sequencer.sv
`timescale 1ns / 1ps
// Servo pulse sequencer: CHANNELS servo lines pulsed one slot after another.
// Input channel (req_): each item is either one timer tick or a write of a
// channel's pending pulse width. Every accepted item yields exactly one result
// item on the rsp_ channel: the line levels, the running slot's channel and a
// flag that marks the tick that began a new frame.
// The result is registered: the result of an item accepted at one edge is valid
// after that edge. One item is taken per clock while the output register can be
// emptied; the tick update is combinational and the pending width store read
// is prefetched for the next slot's channel so a slot can start on any tick.
// When the receiver stalls, the result is held in the output register and
// req_ready drops until it is taken; req_ready is high whenever the output
// register is empty or being emptied in the same cycle.
// The csr_ port writes channel_enable (index 0) and frame_min_ticks (index 1)
// with no wait states. Reset sets all lines low, channel 0 current, the enable
// mask to zero and the frame minimum to 3333 ticks, and pending widths read as
// zero; the block accepts items in the first cycle after reset.
module multiplexed_servo_pulse_sequencer #(
   parameter int CHANNELS     = mssp_pkg::CHANNELS_DEF,
   parameter int PERIOD_TICKS = mssp_pkg::PERIOD_TICKS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mssp_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mssp_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_we,
   input  logic [mssp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mssp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mssp_pkg::*;

   localparam int CHW  = $clog2(CHANNELS);
   localparam int PHW  = $clog2(PERIOD_TICKS);
   localparam logic [CHW-1:0] LAST_CH   = CHW'(CHANNELS - 1);
   localparam logic [PHW-1:0] LAST_PH   = PHW'(PERIOD_TICKS - 1);

   function automatic logic [CHW-1:0] next_chan(input logic [CHW-1:0] c);
      return (c == LAST_CH) ? '0 : c + 1'b1;
   endfunction

   logic [LINE_W-1:0]  enable_ff;
   logic [WIDTH_W-1:0] frame_min_ff;

   logic [CHW-1:0]     slot_ff, slot_in;
   logic [PHW-1:0]     phase_ff, phase_in;
   logic [WIDTH_W-1:0] slot_el_ff, slot_el_in;
   logic [WIDTH_W-1:0] frame_el_ff, frame_el_in;
   logic [WIDTH_W-1:0] active_ff, active_in;
   logic               fin_ff, fin_in;
   logic [LINE_W-1:0]  lines_ff, lines_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   wr_type             wr;
   logic [WIDTH_W-1:0] next_pend;
   logic [LINE_W-1:0]  cur_wide, start_wide;
   logic               start;
   logic [CHW-1:0]     start_ch;
   logic               fstart;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         frame_min_ff <= FRAME_MIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE: enable_ff    <= csr_wdata[LINE_W-1:0];
            CSR_FRAME_MIN:      frame_min_ff <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign wr.en   = accept && (req_payload.operation == OP_WRITE) &&
                    (5'(req_payload.channel) < 5'(CHANNELS));
   assign wr.chan = CHAN_MAX_W'(req_payload.channel);
   assign wr.data = req_payload.width;

   // The store always presents the pending width of the channel after the
   // running slot, as seen after the item in flight.
   mssp_pend_store #(
      .CHANNELS (CHANNELS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (next_chan(slot_in)),
      .rd_data (next_pend)
   );

   assign cur_wide   = LINE_W'(slot_ff);
   assign start_ch   = next_chan(slot_ff);
   assign start_wide = LINE_W'(start_ch);

   always_comb begin
      slot_in     = slot_ff;
      phase_in    = phase_ff;
      slot_el_in  = slot_el_ff;
      frame_el_in = frame_el_ff;
      active_in   = active_ff;
      fin_in      = fin_ff;
      lines_in    = lines_ff;
      start       = 1'b0;
      fstart      = 1'b0;

      if (accept && req_payload.operation == OP_TICK) begin
         phase_in    = (phase_ff == LAST_PH) ? '0 : phase_ff + 1'b1;
         slot_el_in  = (slot_el_ff == COUNT_MAX) ? slot_el_ff : slot_el_ff + 1'b1;
         frame_el_in = (frame_el_ff == COUNT_MAX) ? frame_el_ff : frame_el_ff + 1'b1;

         if (!fin_ff && slot_el_in >= active_ff) begin
            if (cur_wide < LINE_W'(LINE_W)) begin
               lines_in[cur_wide[LINE_IDX_W-1:0]] = 1'b0;
            end
            fin_in = 1'b1;
         end

         if (phase_in == '0 && fin_in) begin
            if (slot_ff != LAST_CH) begin
               start = 1'b1;
            end else if (frame_el_in >= frame_min_ff) begin
               start       = 1'b1;
               fstart      = 1'b1;
               frame_el_in = '0;
            end
         end

         if (start) begin
            slot_in    = start_ch;
            slot_el_in = '0;
            active_in  = next_pend;
            fin_in     = 1'b0;
            if (start_wide < LINE_W'(LINE_W) && next_pend != '0 &&
                enable_ff[start_wide[LINE_IDX_W-1:0]]) begin
               lines_in[start_wide[LINE_IDX_W-1:0]] = 1'b1;
            end
         end
      end

      rsp_in.pulse_lines     = lines_in;
      rsp_in.current_channel = CHAN_FIELD_W'(slot_in);
      rsp_in.frame_start     = fstart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         phase_ff     <= '0;
         slot_el_ff   <= '0;
         frame_el_ff  <= '0;
         active_ff    <= '0;
         fin_ff       <= 1'b0;
         lines_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         phase_ff    <= phase_in;
         slot_el_ff  <= slot_el_in;
         frame_el_ff <= frame_el_in;
         active_ff   <= active_in;
         fin_ff      <= fin_in;
         lines_ff    <= lines_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
